FILE: sv/hsvrgb_pkg.sv
// hsvrgb_pkg: widths, constants and the sector code shared by the hsv to rgb converter
// no dependencies; used by hsvrgb_div and hsv_to_rgb_converter_unit

package hsvrgb_pkg;

    // field widths
    localparam int HUE_W         = 17;
    localparam int CH_W          = 8;
    localparam int HUE_FRAC_BITS = 8;

    // one sector is 60 degrees; 60 = 15 << 2
    localparam int SECTOR_SPAN = 60 << HUE_FRAC_BITS;
    localparam int REM_W       = $clog2(SECTOR_SPAN);
    localparam int SPAN_W      = $clog2(SECTOR_SPAN + 1);
    localparam int CMP_W       = 32;

    // full scale and the shared divisor: 255 * sector span = 3825 << DIV_SHIFT
    localparam int FULL_SCALE = 255;
    localparam int SPAN_ODD   = 15;
    localparam int DIV_BASE   = FULL_SCALE * SPAN_ODD;
    localparam int DIV_SHIFT  = HUE_FRAC_BITS + 2;
    localparam int BIG        = FULL_SCALE * SECTOR_SPAN;
    localparam int BIG_W      = $clog2(BIG + 1);
    localparam int PROD_W     = BIG_W + CH_W;
    localparam int PTERM_W    = $clog2(DIV_BASE + 1);

    // dividend of the shared divide, at most 255 * 3825
    localparam int SCALE_W = $clog2(FULL_SCALE * DIV_BASE + 1);

    // reciprocal of the divisor, estimate is exact or one low
    localparam int    RECIP_SHIFT = 32;
    localparam longint RECIP      = (longint'(1) << RECIP_SHIFT) / DIV_BASE;
    localparam int    RECIP_W     = $clog2(RECIP + 1);
    localparam int    EST_PROD_W  = SCALE_W + RECIP_W;

    // hue sector, anything at or past 360 degrees is black
    typedef enum logic [2:0] {
        SECT_R_Y  = 3'd0,
        SECT_Y_G  = 3'd1,
        SECT_G_C  = 3'd2,
        SECT_C_B  = 3'd3,
        SECT_B_M  = 3'd4,
        SECT_M_R  = 3'd5,
        SECT_NONE = 3'd6
    } t_sector;

    localparam int NUM_SECT = 6;

endpackage

FILE: sv/hsvrgb_div.sv
// hsvrgb_div: two-stage divide of a channel dividend by 3825 via reciprocal and correction
// depends on hsvrgb_pkg

module hsvrgb_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [hsvrgb_pkg::SCALE_W-1:0] i_num,
    output logic [hsvrgb_pkg::CH_W-1:0]    o_quot
);
    import hsvrgb_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP_V    = RECIP_W'(RECIP);
    localparam logic [SCALE_W-1:0] DIV_BASE_V = SCALE_W'(DIV_BASE);

    logic [SCALE_W-1:0]    r_num;
    logic [CH_W-1:0]       r_est;
    logic [CH_W-1:0]       r_quot;
    logic [EST_PROD_W-1:0] est_prod;
    logic [CH_W-1:0]       n_est;
    logic [SCALE_W-1:0]    back_prod;
    logic [SCALE_W-1:0]    resid;
    logic [CH_W-1:0]       n_quot;

    // quotient estimate from the reciprocal, never above the true quotient
    always_comb begin
        est_prod = EST_PROD_W'(i_num) * EST_PROD_W'(RECIP_V);
        n_est    = est_prod[RECIP_SHIFT +: CH_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= i_num;
            r_est <= n_est;
        end
    end

    // fix up the estimate when the residue still holds one divisor
    always_comb begin
        back_prod = SCALE_W'(r_est) * DIV_BASE_V;
        resid     = r_num - back_prod;
        n_quot    = r_est + CH_W'(resid >= DIV_BASE_V);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

FILE: sv/hsv_to_rgb_converter_unit.sv
// hsv_to_rgb_converter_unit: six-stage pipelined hsv to rgb pixel converter
// depends on hsvrgb_pkg and hsvrgb_div
//
// usage
//   input channel: i_valid, i_hue, i_saturation, i_brightness, stalled by o_stall.
//   output channel: o_valid, o_red, o_green, o_blue, stalled by i_stall.
//   a transfer happens on a rising edge with valid high and stall low.
//   hue is in degrees with HUE_FRAC_BITS fractional bits; a hue of 360 or more
//   gives black. saturation and brightness use 255 as full scale.
//   o_valid rises once the pixel has passed through the six register stages; one
//   pixel is taken every cycle while o_stall is low, since the stages all advance
//   together.
//   the stages are sector select, partial products, channel dividends,
//   reciprocal estimate, divide correction and the sector mux into the
//   output register.
//   when i_stall is high with a result waiting, the whole pipeline holds and
//   o_stall rises; nothing is lost or repeated. bubbles are not squeezed out.
//   reset clears all valid bits, so o_valid is low after reset.

module hsv_to_rgb_converter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hsvrgb_pkg::HUE_W-1:0] i_hue,
    input  logic [hsvrgb_pkg::CH_W-1:0]  i_saturation,
    input  logic [hsvrgb_pkg::CH_W-1:0]  i_brightness,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hsvrgb_pkg::CH_W-1:0]  o_red,
    output logic [hsvrgb_pkg::CH_W-1:0]  o_green,
    output logic [hsvrgb_pkg::CH_W-1:0]  o_blue
);
    import hsvrgb_pkg::*;

    localparam int NUM_STAGE = 6;

    localparam logic [BIG_W-1:0]   BIG_V      = BIG_W'(BIG);
    localparam logic [SPAN_W-1:0]  SPAN_V     = SPAN_W'(SECTOR_SPAN);
    localparam logic [PTERM_W-1:0] FULL_V     = PTERM_W'(FULL_SCALE);
    localparam logic [PTERM_W-1:0] SPAN_ODD_V = PTERM_W'(SPAN_ODD);

    logic                 en;
    logic [NUM_STAGE-1:0] r_vld;

    // stage 1 signals
    logic [CMP_W-1:0] hue_ext;
    logic [CMP_W-1:0] sect_lo;
    logic [CMP_W-1:0] sect_hi;
    t_sector          n_sect;
    logic [REM_W-1:0] n_rem;
    t_sector          r1_sect;
    logic [REM_W-1:0] r1_rem;
    logic [CH_W-1:0]  r1_sat;
    logic [CH_W-1:0]  r1_bri;

    // stage 2 signals
    logic [SPAN_W-1:0]  span_less;
    t_sector            r2_sect;
    logic [CH_W-1:0]    r2_bri;
    logic [BIG_W-1:0]   r2_xq;
    logic [BIG_W-1:0]   r2_xt;
    logic [PTERM_W-1:0] r2_pterm;

    // stage 3 signals
    logic [PROD_W-1:0]  prod_q;
    logic [PROD_W-1:0]  prod_t;
    t_sector            r3_sect;
    logic [CH_W-1:0]    r3_bri;
    logic [SCALE_W-1:0] r3_mq;
    logic [SCALE_W-1:0] r3_mt;
    logic [SCALE_W-1:0] r3_mp;

    // stages 4 and 5 carry the sector and brightness beside the dividers
    t_sector         r4_sect;
    logic [CH_W-1:0] r4_bri;
    t_sector         r5_sect;
    logic [CH_W-1:0] r5_bri;
    logic [CH_W-1:0] r5_q;
    logic [CH_W-1:0] r5_t;
    logic [CH_W-1:0] r5_p;

    // output stage
    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;

    // whole pipeline advances unless a waiting result is stalled
    assign en      = !(r_vld[NUM_STAGE-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NUM_STAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STAGE-2:0], i_valid};
        end
    end

    // stage 1: sector select by parallel compares and remainder in sector
    always_comb begin
        hue_ext = CMP_W'(i_hue);
        n_sect  = SECT_NONE;
        n_rem   = '0;
        sect_lo = '0;
        sect_hi = '0;
        for (int k = 0; k < NUM_SECT; k++) begin
            sect_lo = CMP_W'(k * SECTOR_SPAN);
            sect_hi = CMP_W'((k + 1) * SECTOR_SPAN);
            if (hue_ext >= sect_lo && hue_ext < sect_hi) begin
                n_sect = t_sector'(3'(k));
                n_rem  = REM_W'(hue_ext - sect_lo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sect <= n_sect;
            r1_rem  <= n_rem;
            r1_sat  <= i_saturation;
            r1_bri  <= i_brightness;
        end
    end

    // stage 2: saturation products for q and t, and the p factor
    assign span_less = SPAN_V - SPAN_W'(r1_rem);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sect  <= r1_sect;
            r2_bri   <= r1_bri;
            r2_xq    <= BIG_W'(r1_rem) * BIG_W'(r1_sat);
            r2_xt    <= BIG_W'(span_less) * BIG_W'(r1_sat);
            r2_pterm <= (FULL_V - PTERM_W'(r1_sat)) * SPAN_ODD_V;
        end
    end

    // stage 3: brightness products, scaled down to a common divisor of 3825
    always_comb begin
        prod_q = PROD_W'(r2_bri) * PROD_W'(BIG_V - r2_xq);
        prod_t = PROD_W'(r2_bri) * PROD_W'(BIG_V - r2_xt);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sect <= r2_sect;
            r3_bri  <= r2_bri;
            r3_mq   <= prod_q[DIV_SHIFT +: SCALE_W];
            r3_mt   <= prod_t[DIV_SHIFT +: SCALE_W];
            r3_mp   <= SCALE_W'(r2_bri) * SCALE_W'(r2_pterm);
        end
    end

    // stages 4 and 5: one divider lane per derived channel
    hsvrgb_div u_div_q (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r3_mq),
        .o_quot (r5_q)
    );

    hsvrgb_div u_div_t (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r3_mt),
        .o_quot (r5_t)
    );

    hsvrgb_div u_div_p (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r3_mp),
        .o_quot (r5_p)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sect <= r3_sect;
            r4_bri  <= r3_bri;
            r5_sect <= r4_sect;
            r5_bri  <= r4_bri;
        end
    end

    // stage 6: sector mux into the output register
    always_comb begin
        unique case (r5_sect)
            SECT_R_Y: begin
                n_red = r5_bri; n_green = r5_t;   n_blue = r5_p;
            end
            SECT_Y_G: begin
                n_red = r5_q;   n_green = r5_bri; n_blue = r5_p;
            end
            SECT_G_C: begin
                n_red = r5_p;   n_green = r5_bri; n_blue = r5_t;
            end
            SECT_C_B: begin
                n_red = r5_p;   n_green = r5_q;   n_blue = r5_bri;
            end
            SECT_B_M: begin
                n_red = r5_t;   n_green = r5_p;   n_blue = r5_bri;
            end
            SECT_M_R: begin
                n_red = r5_bri; n_green = r5_p;   n_blue = r5_q;
            end
            default: begin
                n_red = '0;     n_green = '0;     n_blue = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // stall toward the source only while a result waits at the output
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("o_stall high with no result waiting");

    // derived channels never exceed brightness
    a_chan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_STAGE-2] |-> (r5_q <= r5_bri && r5_t <= r5_bri && r5_p <= r5_bri))
        else $error("divider lane result above brightness");

    // a hue past the last sector comes out black
    a_black_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[NUM_STAGE-2] && r5_sect == SECT_NONE)
            |=> (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("out of range hue did not give black");

    // a transfer taken in leaves the first stage valid on the next edge
    a_enter_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted pixel lost at pipeline entry");

endmodule

FILE: dv/hsv_rgb_checker.sv
// hsv_rgb_checker: watches both channels of the hsv to rgb converter, predicts each pixel
// and compares every output transfer with the oldest prediction
// depends on hsvrgb_pkg for widths, the sector span and the sector codes
`timescale 1ns / 100ps

module hsv_rgb_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [hsvrgb_pkg::HUE_W-1:0] i_hue,
    input  logic [hsvrgb_pkg::CH_W-1:0]  i_saturation,
    input  logic [hsvrgb_pkg::CH_W-1:0]  i_brightness,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [hsvrgb_pkg::CH_W-1:0]  i_red,
    input  logic [hsvrgb_pkg::CH_W-1:0]  i_green,
    input  logic [hsvrgb_pkg::CH_W-1:0]  i_blue,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_result_count
);
    import hsvrgb_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb_pixel;

    t_rgb_pixel  expected_rgb_q[$];
    t_rgb_pixel  oldest_rgb;
    int          mismatch_cnt = 0;
    int          pixel_cnt    = 0;

    // exact rational channels, truncated once, then the six-way sector mux
    function automatic t_rgb_pixel predict_rgb(input logic [HUE_W-1:0] hue,
                                               input logic [CH_W-1:0]  sat,
                                               input logic [CH_W-1:0]  bri);
        longint unsigned span;
        longint unsigned full;
        longint unsigned sect;
        longint unsigned remd;
        longint unsigned v_ch;
        longint unsigned p_ch;
        longint unsigned q_ch;
        longint unsigned t_ch;
        t_rgb_pixel      pix;
        span = SECTOR_SPAN;
        full = FULL_SCALE * span;
        sect = hue / span;
        remd = hue % span;
        v_ch = bri;
        p_ch = (bri * (FULL_SCALE - sat)) / FULL_SCALE;
        q_ch = (bri * (full - remd * sat)) / full;
        t_ch = (bri * (full - (span - remd) * sat)) / full;
        pix  = '0;
        if (sect < NUM_SECT) begin
            case (t_sector'(sect[2:0]))
                SECT_R_Y: pix = '{v_ch[7:0], t_ch[7:0], p_ch[7:0]};
                SECT_Y_G: pix = '{q_ch[7:0], v_ch[7:0], p_ch[7:0]};
                SECT_G_C: pix = '{p_ch[7:0], v_ch[7:0], t_ch[7:0]};
                SECT_C_B: pix = '{p_ch[7:0], q_ch[7:0], v_ch[7:0]};
                SECT_B_M: pix = '{t_ch[7:0], p_ch[7:0], v_ch[7:0]};
                SECT_M_R: pix = '{v_ch[7:0], p_ch[7:0], q_ch[7:0]};
                default:  pix = '0;
            endcase
        end
        return pix;
    endfunction

    task automatic check_channel(input string name, input logic [CH_W-1:0] exp_val,
                                 input logic [CH_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_cnt++;
        end
    endtask

    // predict on each input transfer, compare on each output transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                expected_rgb_q.push_back(predict_rgb(i_hue, i_saturation, i_brightness));
            if (i_out_valid && !i_out_stall) begin
                pixel_cnt++;
                if (expected_rgb_q.size() == 0) begin
                    $error("output transfer with no pixel outstanding");
                    mismatch_cnt++;
                end else begin
                    oldest_rgb = expected_rgb_q.pop_front();
                    check_channel("red", oldest_rgb.red, i_red);
                    check_channel("green", oldest_rgb.green, i_green);
                    check_channel("blue", oldest_rgb.blue, i_blue);
                end
            end
        end
        o_fail_count   <= mismatch_cnt;
        o_pending      <= expected_rgb_q.size();
        o_result_count <= pixel_cnt;
    end

endmodule

FILE: dv/tb_hsv_to_rgb_converter_unit.sv
// tb_hsv_to_rgb_converter_unit: drives directed and random pixels into the converter
// under varying idle and stall pressure; depends on hsvrgb_pkg, the block and hsv_rgb_checker
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter_unit;
    import hsvrgb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 430;
    localparam int DRAIN_CYCLES = 12;
    localparam int BLACK_HUE    = NUM_SECT * SECTOR_SPAN;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              i_stall      = 1'b0;
    logic [HUE_W-1:0]  i_hue        = '0;
    logic [CH_W-1:0]   i_saturation = '0;
    logic [CH_W-1:0]   i_brightness = '0;
    logic              o_stall;
    logic              o_valid;
    logic [CH_W-1:0]   o_red;
    logic [CH_W-1:0]   o_green;
    logic [CH_W-1:0]   o_blue;

    int fail_count;
    int pending;
    int result_count;
    int cycle_cnt    = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int sent_cnt     = 0;
    int black_cnt    = 0;

    hsv_to_rgb_converter_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    hsv_rgb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_hue          (i_hue),
        .i_saturation   (i_saturation),
        .i_brightness   (i_brightness),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_red          (o_red),
        .i_green        (o_green),
        .i_blue         (o_blue),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // optional idle cycles, then hold the pixel until its transfer
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
                              input logic [CH_W-1:0] bri);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bri;
        do @(posedge i_clk); while (o_stall);
        sent_cnt++;
        if (hue >= BLACK_HUE)
            black_cnt++;
    endtask

    // mostly in-range hues with random content, some past 360 degrees
    function automatic logic [CH_W-1:0] pick_level();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return '0;
        else if (sel < 20)
            return '1;
        return CH_W'($urandom_range(255));
    endfunction

    task automatic send_random_pixels(input int count);
        logic [HUE_W-1:0] hue;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 85)
                hue = HUE_W'($urandom_range(BLACK_HUE - 1));
            else
                hue = HUE_W'($urandom_range((1 << HUE_W) - 1));
            send_pixel(hue, pick_level(), pick_level());
        end
    endtask

    initial begin
        idle_pct  = 21;
        stall_pct = 62;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sector boundaries at full saturation, then the extremes and black hues
        for (int k = 0; k < NUM_SECT; k++) begin
            send_pixel(HUE_W'(k * SECTOR_SPAN), 8'hff, 8'hff);
            send_pixel(HUE_W'(k * SECTOR_SPAN + SECTOR_SPAN - 1), 8'hff, 8'd200);
        end
        send_pixel(HUE_W'(BLACK_HUE), 8'hff, 8'hff);
        send_pixel('1, 8'hff, 8'hff);
        send_pixel(HUE_W'(BLACK_HUE - 1), 8'h00, 8'hff);
        send_pixel(HUE_W'(SECTOR_SPAN / 2), 8'hff, 8'h00);
        send_pixel(HUE_W'(SECTOR_SPAN / 2), 8'd128, 8'hff);
        send_pixel(HUE_W'(3 * SECTOR_SPAN + SECTOR_SPAN / 2), 8'd77, 8'd133);
        send_pixel('0, 8'h00, 8'h00);

        // random pixels: slow receiver, then slow sender, then full rate
        send_random_pixels(PHASE_ITEMS);
        idle_pct  = 62;
        stall_pct = 21;
        send_random_pixels(PHASE_ITEMS);
        idle_pct  = 0;
        stall_pct = 0;
        send_random_pixels(PHASE_ITEMS);
        i_valid <= 1'b0;

        // drain the pipeline
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("pixels sent: %0d, %0d with hue at or past 360 degrees", sent_cnt, black_cnt);
        $display("pixels checked: %0d over three idle/stall mixes", result_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
